>>> src/assert_macros.svh
// Assertion macros used by the RTL of the pattern match counter.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a consequent follows from an antecedent on the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that a condition never holds
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> src/mpmc_pkg.sv
// Shared constants of the multi-pattern match counter: port widths,
// operation and status codes, default sizes. No dependencies.
package mpmc_pkg;
    localparam int MAX_PATTERNS_DEF    = 1024;
    localparam int MAX_PATTERN_LEN_DEF = 64;

    localparam int OP_W        = 2;
    localparam int SLOT_PORT_W = 10;
    localparam int OFS_PORT_W  = 6;
    localparam int BYTE_W      = 8;
    localparam int PAIR_W      = 16;
    localparam int COUNT_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 32;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_PREPARE = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;
    localparam logic [OP_W-1:0] OP_END     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
endpackage

>>> src/mpmc_ram.sv
// Simple dual-port synchronous RAM with a registered read, one write port.
// No dependencies; used for every table of the match counter.
module mpmc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [(2**ADDR_W)-1:0];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> src/multi_pattern_match_counter_unit.sv
// Channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | operation, pattern_slot, byte_offset,
//         |           |                      | data_byte, pattern_last
// out     | output    | out_valid / out_stall| match_count, status
//
// A load, a failed prepare or an ignored text byte is done in the idle state. A text
// byte is stored, then each due window reads its end pair and shift; on a zero shift
// the bucket is walked, each entry compared byte by byte (text buffer port).
// A successful prepare sweeps the 65536-entry shift table, then walks the pairs of
// each pattern (pattern store and shift table ports).
// Reset clears control state only; tables are rebuilt by prepare. A waiting
// result does not block input; a second end of text waits for the output.
//
// Top level of the Wu-Manber matcher; depends on mpmc_pkg, mpmc_ram and
// assert_macros.svh.
`include "assert_macros.svh"
module multi_pattern_match_counter_unit #(
    parameter int MAX_PATTERNS    = mpmc_pkg::MAX_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = mpmc_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mpmc_pkg::OP_W-1:0]        operation,
    input  logic [mpmc_pkg::SLOT_PORT_W-1:0] pattern_slot,
    input  logic [mpmc_pkg::OFS_PORT_W-1:0]  byte_offset,
    input  logic [mpmc_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             pattern_last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mpmc_pkg::COUNT_W-1:0]     match_count,
    output logic [mpmc_pkg::STATUS_W-1:0]    status
);
    import mpmc_pkg::*;

    localparam int SLOT_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CNT_W   = $clog2(MAX_PATTERNS + 1);
    localparam int OFS_W   = $clog2(MAX_PATTERN_LEN);
    localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PADDR_W = SLOT_W + OFS_W;
    localparam int HEAD_W  = 1 + SLOT_W;
    localparam int LINK_W  = PAIR_W + HEAD_W;
    localparam int NE_W    = POS_W + 1;
    localparam int SUM_W   = POS_W + 2;
    localparam logic [CNT_W-1:0] LOADED_MAX = CNT_W'(MAX_PATTERNS);
    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_PATTERN_LEN);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SWEEP = 5'd1;
    localparam logic [4:0] S_SLOT  = 5'd2;
    localparam logic [4:0] S_LEN   = 5'd3;
    localparam logic [4:0] S_B0    = 5'd4;
    localparam logic [4:0] S_B1    = 5'd5;
    localparam logic [4:0] S_SK    = 5'd6;
    localparam logic [4:0] S_HD    = 5'd7;
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_TA    = 5'd9;
    localparam logic [4:0] S_TB    = 5'd10;
    localparam logic [4:0] S_TSK   = 5'd11;
    localparam logic [4:0] S_THD   = 5'd12;
    localparam logic [4:0] S_TP0   = 5'd13;
    localparam logic [4:0] S_TP1   = 5'd14;
    localparam logic [4:0] S_TSL   = 5'd15;
    localparam logic [4:0] S_TCMP  = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    // Control and scratch registers
    logic [4:0]          state_reg, state_next;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [LEN_W-1:0]    shortest_reg, shortest_next;
    logic [LEN_W-1:0]    prep_m_reg, prep_m_next;
    logic [STATUS_W-1:0] prep_st_reg, prep_st_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [NE_W-1:0]     next_end_reg, next_end_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic                end_mode_reg, end_mode_next;
    logic [PAIR_W-1:0]   sweep_reg, sweep_next;
    logic [CNT_W-1:0]    slot_i_reg, slot_i_next;
    logic [LEN_W-1:0]    k_reg, k_next;
    logic [BYTE_W-1:0]   prev_reg, prev_next;
    logic [PAIR_W-1:0]   pair_reg, pair_next;
    logic [PAIR_W-1:0]   prefix_reg, prefix_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic [HEAD_W-1:0]   nxt_reg, nxt_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [OFS_W-1:0]    t_lo_reg, t_lo_next;
    logic [PAIR_W-1:0]   tp_reg, tp_next;
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // Memory ports
    logic               pat_we, pat_re;
    logic [PADDR_W-1:0] pat_waddr, pat_raddr;
    logic [BYTE_W-1:0]  pat_rdata;
    logic               len_we, len_re;
    logic [SLOT_W-1:0]  len_waddr, len_raddr;
    logic [LEN_W-1:0]   len_wdata, len_rdata;
    logic               link_we, link_re;
    logic [LINK_W-1:0]  link_wdata, link_rdata;
    logic               skip_we, skip_re;
    logic [PAIR_W-1:0]  skip_waddr, skip_raddr;
    logic [OFS_W-1:0]   skip_wdata, skip_rdata;
    logic               head_we, head_re;
    logic [PAIR_W-1:0]  head_waddr, head_raddr;
    logic [HEAD_W-1:0]  head_wdata, head_rdata;
    logic               text_we, text_re;
    logic [OFS_W-1:0]   text_waddr, text_raddr;
    logic [BYTE_W-1:0]  text_rdata;

    // Datapath helpers
    logic               in_fire, out_fire, load_ok;
    logic [LEN_W-1:0]   load_len, lag, shift_new;
    logic [SUM_W-1:0]   ne_ext, pos_ext;
    logic               cond_text, cond_end, fits;
    logic [OFS_W-1:0]   w_lo, m_lo;
    logic [PAIR_W-1:0]  link_prefix;
    logic [HEAD_W-1:0]  link_nxt;
    logic [COUNT_W-1:0] total_inc;

    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign load_ok   = (32'(pattern_slot) < 32'(MAX_PATTERNS))
                    && (32'(byte_offset) < 32'(MAX_PATTERN_LEN));
    assign load_len  = LEN_W'(byte_offset) + LEN_W'(1);
    assign lag       = LEN_MAX - prep_m_reg;
    assign ne_ext    = SUM_W'(next_end_reg);
    assign pos_ext   = SUM_W'(pos_reg);
    assign cond_text = (ne_ext + SUM_W'(lag)) < pos_ext;
    assign cond_end  = ne_ext < pos_ext;
    assign fits      = (ne_ext + SUM_W'(1) + SUM_W'(len_rdata))
                    <= (pos_ext + SUM_W'(prep_m_reg));
    assign w_lo      = next_end_reg[OFS_W-1:0];
    assign m_lo      = OFS_W'(prep_m_reg);
    assign shift_new = prep_m_reg - LEN_W'(2) - k_reg;
    assign link_prefix = link_rdata[LINK_W-1 -: PAIR_W];
    assign link_nxt    = link_rdata[HEAD_W-1:0];
    assign total_inc   = (total_reg == '1) ? total_reg : total_reg + COUNT_W'(1);

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign match_count = out_count_reg;
    assign status      = out_status_reg;

    // Sequencer: loads, table build, text bytes, window checks and results
    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        shortest_next   = shortest_reg;
        prep_m_next     = prep_m_reg;
        prep_st_next    = prep_st_reg;
        pos_next        = pos_reg;
        next_end_next   = next_end_reg;
        total_next      = total_reg;
        end_mode_next   = end_mode_reg;
        sweep_next      = sweep_reg;
        slot_i_next     = slot_i_reg;
        k_next          = k_reg;
        prev_next       = prev_reg;
        pair_next       = pair_reg;
        prefix_next     = prefix_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        len_next        = len_reg;
        t_lo_next       = t_lo_reg;
        tp_next         = tp_reg;
        out_valid_next  = out_fire ? 1'b0 : out_valid_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        pat_we     = 1'b0;
        pat_waddr  = {SLOT_W'(pattern_slot), OFS_W'(byte_offset)};
        pat_re     = 1'b0;
        pat_raddr  = {slot_i_reg[SLOT_W-1:0], OFS_W'(k_reg + LEN_W'(2))};
        len_we     = 1'b0;
        len_waddr  = SLOT_W'(pattern_slot);
        len_wdata  = load_len;
        len_re     = 1'b0;
        len_raddr  = slot_i_reg[SLOT_W-1:0];
        link_we    = 1'b0;
        link_wdata = {prefix_reg, head_rdata};
        link_re    = 1'b0;
        skip_we    = 1'b0;
        skip_waddr = pair_reg;
        skip_wdata = OFS_W'(shift_new);
        skip_re    = 1'b0;
        skip_raddr = pair_reg;
        head_we    = 1'b0;
        head_waddr = pair_reg;
        head_wdata = {1'b1, slot_i_reg[SLOT_W-1:0]};
        head_re    = 1'b0;
        head_raddr = pair_reg;
        text_we    = 1'b0;
        text_waddr = pos_reg[OFS_W-1:0];
        text_re    = 1'b0;
        text_raddr = w_lo;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (operation)
                        OP_LOAD:
                        begin
                            if (load_ok)
                            begin
                                pat_we       = 1'b1;
                                prep_st_next = ST_EMPTY;
                                if (pattern_last)
                                begin
                                    len_we = 1'b1;
                                    if (loaded_reg != LOADED_MAX)
                                    begin
                                        loaded_next = loaded_reg + CNT_W'(1);
                                    end
                                    if (load_len < shortest_reg)
                                    begin
                                        shortest_next = load_len;
                                    end
                                end
                            end
                        end
                        OP_PREPARE:
                        begin
                            prep_m_next   = shortest_reg;
                            pos_next      = '0;
                            total_next    = '0;
                            next_end_next = NE_W'(shortest_reg - LEN_W'(1));
                            if (loaded_reg == '0)
                            begin
                                prep_st_next = ST_EMPTY;
                            end
                            else if (shortest_reg < LEN_W'(2))
                            begin
                                prep_st_next = ST_SHORT;
                            end
                            else
                            begin
                                prep_st_next = ST_OK;
                                sweep_next   = '0;
                                state_next   = S_SWEEP;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (prep_st_reg == ST_OK && pos_reg != '1)
                            begin
                                text_we       = 1'b1;
                                pos_next      = pos_reg + POS_W'(1);
                                end_mode_next = 1'b0;
                                state_next    = S_CHK;
                            end
                        end
                        default:
                        begin
                            end_mode_next = 1'b1;
                            state_next    = (prep_st_reg == ST_OK) ? S_CHK : S_DONE;
                        end
                    endcase
                end
            end

            // Fill the shift table with m-1 and empty every bucket
            S_SWEEP:
            begin
                skip_we    = 1'b1;
                skip_waddr = sweep_reg;
                skip_wdata = OFS_W'(prep_m_reg - LEN_W'(1));
                head_we    = 1'b1;
                head_waddr = sweep_reg;
                head_wdata = '0;
                sweep_next = sweep_reg + PAIR_W'(1);
                if (sweep_reg == '1)
                begin
                    slot_i_next = '0;
                    state_next  = S_SLOT;
                end
            end

            S_SLOT:
            begin
                if (slot_i_reg == loaded_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    len_re     = 1'b1;
                    state_next = S_LEN;
                end
            end

            // Skip patterns shorter than m, else fetch the first two bytes
            S_LEN:
            begin
                if (len_rdata < prep_m_reg)
                begin
                    slot_i_next = slot_i_reg + CNT_W'(1);
                    state_next  = S_SLOT;
                end
                else
                begin
                    k_next     = '0;
                    pat_re     = 1'b1;
                    pat_raddr  = {slot_i_reg[SLOT_W-1:0], OFS_W'(0)};
                    state_next = S_B0;
                end
            end

            S_B0:
            begin
                prev_next  = pat_rdata;
                pat_re     = 1'b1;
                pat_raddr  = {slot_i_reg[SLOT_W-1:0], OFS_W'(1)};
                state_next = S_B1;
            end

            // Form the pair at offset k and look up its shift
            S_B1:
            begin
                pair_next = {prev_reg, pat_rdata};
                prev_next = pat_rdata;
                if (k_reg == '0)
                begin
                    prefix_next = {prev_reg, pat_rdata};
                end
                skip_re    = 1'b1;
                skip_raddr = {prev_reg, pat_rdata};
                state_next = S_SK;
            end

            // Write back the smaller shift, advance or close the pattern
            S_SK:
            begin
                skip_we = (OFS_W'(shift_new) < skip_rdata);
                if (k_reg == prep_m_reg - LEN_W'(2))
                begin
                    head_re    = 1'b1;
                    state_next = S_HD;
                end
                else
                begin
                    k_next     = k_reg + LEN_W'(1);
                    pat_re     = 1'b1;
                    state_next = S_B1;
                end
            end

            // Push the pattern on the front of its bucket
            S_HD:
            begin
                link_we     = 1'b1;
                head_we     = 1'b1;
                slot_i_next = slot_i_reg + CNT_W'(1);
                state_next  = S_SLOT;
            end

            // Decide whether the next window end is due
            S_CHK:
            begin
                if (end_mode_reg ? cond_end : cond_text)
                begin
                    text_re    = 1'b1;
                    text_raddr = w_lo - OFS_W'(1);
                    state_next = S_TA;
                end
                else
                begin
                    state_next = end_mode_reg ? S_DONE : S_IDLE;
                end
            end

            S_TA:
            begin
                prev_next  = text_rdata;
                text_re    = 1'b1;
                text_raddr = w_lo;
                state_next = S_TB;
            end

            S_TB:
            begin
                pair_next  = {prev_reg, text_rdata};
                skip_re    = 1'b1;
                skip_raddr = {prev_reg, text_rdata};
                state_next = S_TSK;
            end

            S_TSK:
            begin
                if (skip_rdata != '0)
                begin
                    next_end_next = next_end_reg + NE_W'(skip_rdata);
                    state_next    = S_CHK;
                end
                else
                begin
                    head_re    = 1'b1;
                    state_next = S_THD;
                end
            end

            // Empty bucket: step on; else fetch the window's first pair
            S_THD:
            begin
                if (!head_rdata[HEAD_W-1])
                begin
                    next_end_next = next_end_reg + NE_W'(1);
                    state_next    = S_CHK;
                end
                else
                begin
                    cur_next   = head_rdata[SLOT_W-1:0];
                    t_lo_next  = w_lo + OFS_W'(1) - m_lo;
                    text_re    = 1'b1;
                    text_raddr = w_lo + OFS_W'(1) - m_lo;
                    state_next = S_TP0;
                end
            end

            S_TP0:
            begin
                prev_next  = text_rdata;
                text_re    = 1'b1;
                text_raddr = t_lo_reg + OFS_W'(1);
                state_next = S_TP1;
            end

            S_TP1:
            begin
                tp_next    = {prev_reg, text_rdata};
                len_re     = 1'b1;
                len_raddr  = cur_reg;
                link_re    = 1'b1;
                state_next = S_TSL;
            end

            // Filter the bucket entry on prefix, length and text end
            S_TSL:
            begin
                nxt_next = link_nxt;
                len_next = len_rdata;
                if (link_prefix == tp_reg && len_rdata >= prep_m_reg && fits)
                begin
                    k_next     = '0;
                    text_re    = 1'b1;
                    text_raddr = t_lo_reg;
                    pat_re     = 1'b1;
                    pat_raddr  = {cur_reg, OFS_W'(0)};
                    state_next = S_TCMP;
                end
                else if (link_nxt[HEAD_W-1])
                begin
                    cur_next   = link_nxt[SLOT_W-1:0];
                    len_re     = 1'b1;
                    len_raddr  = link_nxt[SLOT_W-1:0];
                    link_re    = 1'b1;
                    state_next = S_TSL;
                end
                else
                begin
                    next_end_next = next_end_reg + NE_W'(1);
                    state_next    = S_CHK;
                end
            end

            // Compare one byte a cycle; count a full match
            S_TCMP:
            begin
                if (text_rdata == pat_rdata && k_reg + LEN_W'(1) != len_reg)
                begin
                    k_next     = k_reg + LEN_W'(1);
                    text_re    = 1'b1;
                    text_raddr = t_lo_reg + OFS_W'(k_reg + LEN_W'(1));
                    pat_re     = 1'b1;
                    pat_raddr  = {cur_reg, OFS_W'(k_reg + LEN_W'(1))};
                end
                else
                begin
                    if (text_rdata == pat_rdata)
                    begin
                        total_next = total_inc;
                    end
                    if (nxt_reg[HEAD_W-1])
                    begin
                        cur_next   = nxt_reg[SLOT_W-1:0];
                        len_re     = 1'b1;
                        len_raddr  = nxt_reg[SLOT_W-1:0];
                        link_re    = 1'b1;
                        state_next = S_TSL;
                    end
                    else
                    begin
                        next_end_next = next_end_reg + NE_W'(1);
                        state_next    = S_CHK;
                    end
                end
            end

            // Hand over the total once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = (prep_st_reg == ST_OK) ? total_reg : '0;
                    out_status_next = prep_st_reg;
                    pos_next        = '0;
                    total_next      = '0;
                    next_end_next   = NE_W'(prep_m_reg - LEN_W'(1));
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state between edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            loaded_reg     <= '0;
            shortest_reg   <= '1;
            prep_m_reg     <= '0;
            prep_st_reg    <= ST_EMPTY;
            pos_reg        <= '0;
            next_end_reg   <= '0;
            total_reg      <= '0;
            end_mode_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loaded_reg     <= loaded_next;
            shortest_reg   <= shortest_next;
            prep_m_reg     <= prep_m_next;
            prep_st_reg    <= prep_st_next;
            pos_reg        <= pos_next;
            next_end_reg   <= next_end_next;
            total_reg      <= total_next;
            end_mode_reg   <= end_mode_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Scratch and result payload
    always_ff @(posedge clk)
    begin
        sweep_reg      <= sweep_next;
        slot_i_reg     <= slot_i_next;
        k_reg          <= k_next;
        prev_reg       <= prev_next;
        pair_reg       <= pair_next;
        prefix_reg     <= prefix_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        len_reg        <= len_next;
        t_lo_reg       <= t_lo_next;
        tp_reg         <= tp_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    // Pattern bytes, one slot of MAX_PATTERN_LEN bytes per pattern
    mpmc_ram #(.DATA_W(BYTE_W), .ADDR_W(PADDR_W)) u_pat_ram (
        .clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(data_byte),
        .re(pat_re), .raddr(pat_raddr), .rdata(pat_rdata)
    );

    // Pattern lengths
    mpmc_ram #(.DATA_W(LEN_W), .ADDR_W(SLOT_W)) u_len_ram (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .re(len_re), .raddr(len_raddr), .rdata(len_rdata)
    );

    // Prefix pair and bucket link per pattern
    mpmc_ram #(.DATA_W(LINK_W), .ADDR_W(SLOT_W)) u_link_ram (
        .clk(clk), .we(link_we), .waddr(slot_i_reg[SLOT_W-1:0]), .wdata(link_wdata),
        .re(link_re), .raddr(len_raddr), .rdata(link_rdata)
    );

    // Shift table indexed by byte pair
    mpmc_ram #(.DATA_W(OFS_W), .ADDR_W(PAIR_W)) u_skip_ram (
        .clk(clk), .we(skip_we), .waddr(skip_waddr), .wdata(skip_wdata),
        .re(skip_re), .raddr(skip_raddr), .rdata(skip_rdata)
    );

    // Bucket heads indexed by the pair at m-2
    mpmc_ram #(.DATA_W(HEAD_W), .ADDR_W(PAIR_W)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
    );

    // Circular text buffer
    mpmc_ram #(.DATA_W(BYTE_W), .ADDR_W(OFS_W)) u_text_ram (
        .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(data_byte),
        .re(text_re), .raddr(text_raddr), .rdata(text_rdata)
    );

    // Checks
    `ASSERT_IMPL(a_out_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_DONE, "result raised outside done state")
    `ASSERT_IMPL(a_check_needs_ok, clk, rst_n, state_reg == S_CHK, prep_st_reg == ST_OK, "window check without prepared set")
    `ASSERT_IMPL(a_skip_below_m, clk, rst_n, skip_we, LEN_W'(skip_wdata) < prep_m_reg, "shift not below m")
    `ASSERT_NEVER(a_loaded_bound, clk, rst_n, loaded_reg > LOADED_MAX, "pattern count beyond limit")
endmodule
